@@ src/wfps_pkg.sv @@
// ----------------------------------------------------------------------------
// Weighted farthest point sampling package
// Shared types and widths for the candidate cells and the sampling core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wfps_pkg;

  localparam int CoordW = 16;
  localparam int VidW   = 16;
  localparam int WtW    = 16;
  localparam int DistW  = 34;
  localparam int ScoreW = DistW + WtW;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
  } pos_t;

  // Chosen point broadcast down the chain, one cell per cycle.
  typedef struct packed {
    logic            valid;
    logic            first;
    logic [VidW-1:0] vid;
    pos_t            pos;
  } tok_t;

  // Running best candidate, trailing the chosen point by two cells.
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [ScoreW-1:0] score;
    logic [VidW-1:0]   vid;
    pos_t              pos;
  } best_t;

  typedef struct packed {
    logic            en;
    logic [VidW-1:0] vid;
    logic [WtW-1:0]  weight;
    pos_t            pos;
  } load_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PASS,
    S_EMIT
  } state_e;

endpackage

`default_nettype wire

@@ src/weighted_farthest_point_sampling_core.sv @@
// ----------------------------------------------------------------------------
// Weighted farthest point sampling core
// Loads a candidate set into a chain of cells and picks samples greedily by
// weight times squared distance to the nearest chosen point.
// ----------------------------------------------------------------------------
//  Channel | Direction | Beat contents
//  --------+-----------+-------------------------------------------------
//  in      | input     | vertex_id, weight, pos_x, pos_y, pos_z, last
//  out     | output    | sample_vertex, final_sample
//
//  Loading accepts one beat per cycle while idle; the input stalls while a run is active.
//  Each sample costs one pass down the chain; a run emits at most min(SAMPLES, count) samples.
//  Reset is asynchronous and takes effect at once; no clearing pass is needed.
//  A stalled output holds the run in the emit state until the previous sample is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module weighted_farthest_point_sampling_core #(
  parameter int MAX_CANDIDATES = 64,
  parameter int SAMPLES        = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] vertex_id_i,
  input  logic [15:0] weight_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [15:0] pos_z_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] sample_vertex_o,
  output logic        final_sample_o
);
  import wfps_pkg::*;

  localparam int LcW = $clog2(MAX_CANDIDATES + 1);
  localparam int EcW = $clog2(SAMPLES + 1);

  state_e state_q, state_d;

  logic [LcW-1:0]  load_cnt_q;
  logic [EcW-1:0]  emit_cnt_q;
  logic [EcW-1:0]  target_q;
  logic [VidW-1:0] head_vid_q;
  pos_t            head_pos_q;
  logic [VidW-1:0] pend_vid_q;
  logic            win_found_q;
  logic [VidW-1:0] win_vid_q;
  pos_t            win_pos_q;
  tok_t            tok_q;
  logic            inj_q;
  logic            seed_valid_q;
  logic            out_valid_q;
  logic [VidW-1:0] sample_q;
  logic            final_q;

  logic            in_acc;
  logic            full;
  logic            start;
  logic            slot_free;
  logic            is_final;
  logic            out_load;
  logic            clear_run;
  logic            next_tok;
  logic [LcW-1:0]  n_new;
  logic [VidW-1:0] head_vid;
  pos_t            in_pos;
  pos_t            head_pos;
  load_t           ld;
  best_t           seed;

  tok_t  tok_w  [0:MAX_CANDIDATES];
  best_t best_w [0:MAX_CANDIDATES];

  always_comb begin
    in_pos.x = pos_x_i;
    in_pos.y = pos_y_i;
    in_pos.z = pos_z_i;
    full     = (load_cnt_q == LcW'(MAX_CANDIDATES));
    n_new    = full ? load_cnt_q : load_cnt_q + LcW'(1);
    head_vid = (load_cnt_q == '0) ? vertex_id_i : head_vid_q;
    head_pos = (load_cnt_q == '0) ? in_pos : head_pos_q;
    is_final = !((emit_cnt_q < target_q) && win_found_q);
    slot_free = !out_valid_q || !out_stall_i;
    ld.en     = in_acc && !full;
    ld.vid    = vertex_id_i;
    ld.weight = weight_i;
    ld.pos    = in_pos;
    seed       = '0;
    seed.valid = seed_valid_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc && last_i) state_d = S_PASS;
      S_PASS: if (best_w[MAX_CANDIDATES].valid) state_d = S_EMIT;
      S_EMIT: if (slot_free) state_d = is_final ? S_IDLE : S_PASS;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    in_acc     = in_valid_i && (state_q == S_IDLE);
    start      = in_acc && last_i;
    out_load   = (state_q == S_EMIT) && slot_free;
    clear_run  = out_load && is_final;
    next_tok   = out_load && !is_final;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      load_cnt_q   <= '0;
      emit_cnt_q   <= '0;
      tok_q        <= '0;
      inj_q        <= 1'b0;
      seed_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      inj_q        <= tok_q.valid;
      seed_valid_q <= inj_q;
      if (clear_run) begin
        load_cnt_q <= '0;
      end else if (ld.en) begin
        load_cnt_q <= load_cnt_q + LcW'(1);
      end
      if (start) begin
        emit_cnt_q <= EcW'(1);
      end else if (next_tok) begin
        emit_cnt_q <= emit_cnt_q + EcW'(1);
      end
      if (start) begin
        tok_q.valid <= 1'b1;
        tok_q.first <= 1'b1;
        tok_q.vid   <= head_vid;
        tok_q.pos   <= head_pos;
      end else if (next_tok) begin
        tok_q.valid <= 1'b1;
        tok_q.first <= 1'b0;
        tok_q.vid   <= win_vid_q;
        tok_q.pos   <= win_pos_q;
      end else begin
        tok_q.valid <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld.en && (load_cnt_q == '0)) begin
      head_vid_q <= vertex_id_i;
      head_pos_q <= in_pos;
    end
    if (start) begin
      pend_vid_q <= head_vid;
      target_q   <= (32'(n_new) < SAMPLES) ? EcW'(n_new) : EcW'(SAMPLES);
    end else if (next_tok) begin
      pend_vid_q <= win_vid_q;
    end
    if ((state_q == S_PASS) && best_w[MAX_CANDIDATES].valid) begin
      win_found_q <= best_w[MAX_CANDIDATES].found;
      win_vid_q   <= best_w[MAX_CANDIDATES].vid;
      win_pos_q   <= best_w[MAX_CANDIDATES].pos;
    end
    if (out_load) begin
      sample_q <= pend_vid_q;
      final_q  <= is_final;
    end
  end

  assign tok_w[0]  = tok_q;
  assign best_w[0] = seed;

  for (genvar i = 0; i < MAX_CANDIDATES; i++) begin : g_cell
    load_t cell_ld;

    always_comb begin
      cell_ld    = ld;
      cell_ld.en = ld.en && (load_cnt_q == LcW'(i));
    end

    wfps_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .load_i (cell_ld),
      .clear_i(clear_run),
      .tok_i  (tok_w[i]),
      .tok_o  (tok_w[i+1]),
      .best_i (best_w[i]),
      .best_o (best_w[i+1])
    );
  end

  assign out_valid_o     = out_valid_q;
  assign sample_vertex_o = sample_q;
  assign final_sample_o  = final_q;

`ifndef ASSERT_OFF
  a_best_only_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_w[MAX_CANDIDATES].valid |-> (state_q == S_PASS))
    else $error("best token left the chain outside a pass");

  a_tok_starts_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_q.valid |-> (state_q == S_PASS))
    else $error("chosen point injected outside a pass");

  a_emit_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (emit_cnt_q <= target_q))
    else $error("more samples emitted than the run target");

  a_idle_no_load_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) && slot_free |=> out_valid_o)
    else $error("sample beat not presented after emit");
`endif

endmodule

`default_nettype wire

@@ src/wfps_cell.sv @@
// ----------------------------------------------------------------------------
// Candidate cell
// Holds one candidate, updates its nearest distance as a chosen point passes
// and folds its registered score into the running best that trails the chosen point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wfps_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wfps_pkg::load_t load_i,
  input  logic            clear_i,
  input  wfps_pkg::tok_t  tok_i,
  output wfps_pkg::tok_t  tok_o,
  input  wfps_pkg::best_t best_i,
  output wfps_pkg::best_t best_o
);
  import wfps_pkg::*;

  logic              loaded_q;
  logic              excl_q;
  logic [VidW-1:0]   vid_q;
  logic [WtW-1:0]    wt_q;
  pos_t              pos_q;
  logic [DistW-1:0]  near_q;
  logic [ScoreW-1:0] score_q;
  tok_t              tok_q;
  best_t             best_q;

  logic signed [CoordW:0]     dx, dy, dz;
  logic [2*CoordW-1:0]        sx, sy, sz;
  logic [DistW-1:0]           dsq;
  logic                       hit;
  logic                       take_best;
  best_t                      best_d;

  always_comb begin
    dx   = $signed({pos_q.x[CoordW-1], pos_q.x}) - $signed({tok_i.pos.x[CoordW-1], tok_i.pos.x});
    dy   = $signed({pos_q.y[CoordW-1], pos_q.y}) - $signed({tok_i.pos.y[CoordW-1], tok_i.pos.y});
    dz   = $signed({pos_q.z[CoordW-1], pos_q.z}) - $signed({tok_i.pos.z[CoordW-1], tok_i.pos.z});
    sx   = dx * dx;
    sy   = dy * dy;
    sz   = dz * dz;
    dsq  = DistW'(sx) + DistW'(sy) + DistW'(sz);
    hit  = tok_i.valid && loaded_q;
  end

  always_comb begin
    take_best = best_i.valid && loaded_q && !excl_q &&
                (!best_i.found || (score_q > best_i.score));
    best_d    = best_i;
    if (take_best) begin
      best_d.found = 1'b1;
      best_d.score = score_q;
      best_d.vid   = vid_q;
      best_d.pos   = pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
      excl_q   <= 1'b0;
      tok_q    <= '0;
      best_q   <= '0;
    end else begin
      tok_q  <= tok_i;
      best_q <= best_d;
      if (load_i.en) begin
        loaded_q <= 1'b1;
        excl_q   <= 1'b0;
      end else if (clear_i) begin
        loaded_q <= 1'b0;
      end else if (hit && (tok_i.vid == vid_q)) begin
        excl_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.en) begin
      vid_q <= load_i.vid;
      wt_q  <= load_i.weight;
      pos_q <= load_i.pos;
    end
    if (hit && (tok_i.first || (dsq < near_q))) begin
      near_q <= dsq;
    end
    score_q <= near_q * wt_q;
  end

  assign tok_o  = tok_q;
  assign best_o = best_q;

endmodule

`default_nettype wire

@@ sim/tb_weighted_farthest_point_sampling_core.sv @@
// ----------------------------------------------------------------------------
// Testbench for the weighted farthest point sampling core
// Loads candidate sets of many sizes and kinds, including overfull sets,
// duplicate vertex ids, zero weights, ties and extreme coordinates. Both
// channels idle in random bursts. A scoreboard predicts the chosen samples
// of every set and compares each output beat with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_weighted_farthest_point_sampling_core;

  localparam int CandDepth  = 64;
  localparam int SampleGoal = 8;
  localparam int ItemGoal   = 460;
  localparam int QuietFrom  = 400;

  typedef struct {
    logic [15:0] vertex;
    logic        fin;
  } sample_t;

  class sampling_scoreboard;
    logic [15:0] vid_mem    [CandDepth];
    logic [15:0] weight_mem [CandDepth];
    longint      px_mem     [CandDepth];
    longint      py_mem     [CandDepth];
    longint      pz_mem     [CandDepth];
    longint      nearest_sq [CandDepth];
    bit          excluded   [CandDepth];
    int          stored;
    sample_t     expected_q [$];
    int          errors;

    function new();
      stored = 0;
      errors = 0;
    endfunction

    function longint sq_dist(int a, int b);
      longint dx, dy, dz;
      dx = px_mem[a] - px_mem[b];
      dy = py_mem[a] - py_mem[b];
      dz = pz_mem[a] - pz_mem[b];
      return dx * dx + dy * dy + dz * dz;
    endfunction

    function void absorb(int c, bit first);
      longint d;
      for (int i = 0; i < stored; i++) begin
        if (vid_mem[i] == vid_mem[c]) excluded[i] = 1'b1;
        d = sq_dist(i, c);
        if (first || d < nearest_sq[i]) nearest_sq[i] = d;
      end
    endfunction

    function void note_input(logic [15:0] vid, logic [15:0] wt, logic [15:0] x,
                             logic [15:0] y, logic [15:0] z, logic last);
      sample_t s;
      int      goal;
      int      count;
      int      best;
      longint  best_score;
      longint  score;
      bit      found;
      if (stored < CandDepth) begin
        vid_mem[stored]    = vid;
        weight_mem[stored] = wt;
        px_mem[stored]     = longint'($signed(x));
        py_mem[stored]     = longint'($signed(y));
        pz_mem[stored]     = longint'($signed(z));
        stored++;
      end
      if (!last) return;
      goal = (stored < SampleGoal) ? stored : SampleGoal;
      for (int i = 0; i < CandDepth; i++) excluded[i] = 1'b0;
      s.vertex = vid_mem[0];
      s.fin    = 1'b0;
      count = 1;
      absorb(0, 1'b1);
      while (count < goal) begin
        found      = 1'b0;
        best       = 0;
        best_score = 0;
        for (int i = 0; i < stored; i++) begin
          if (!excluded[i]) begin
            score = nearest_sq[i] * longint'(weight_mem[i]);
            if (!found || score > best_score) begin
              found      = 1'b1;
              best       = i;
              best_score = score;
            end
          end
        end
        if (!found) break;
        expected_q = {expected_q, s};
        s.vertex = vid_mem[best];
        s.fin    = 1'b0;
        count++;
        absorb(best, 1'b0);
      end
      s.fin = 1'b1;
      expected_q = {expected_q, s};
      stored = 0;
    endfunction

    function void check_result(logic [15:0] vertex, logic fin);
      sample_t s;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected sample beat, vertex %h final %b", $time, vertex, fin);
        errors++;
        return;
      end
      s = expected_q.pop_front();
      if (vertex !== s.vertex) begin
        $display("%0t: sample_vertex expected %h actual %h", $time, s.vertex, vertex);
        errors++;
      end
      if (fin !== s.fin) begin
        $display("%0t: final_sample expected %b actual %b", $time, s.fin, fin);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [15:0] vertex_id = '0;
  logic [15:0] weight    = '0;
  logic [15:0] pos_x     = '0;
  logic [15:0] pos_y     = '0;
  logic [15:0] pos_z     = '0;
  logic        last      = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] sample_vertex;
  logic        final_sample;

  bit                 quiet = 1'b0;
  int                 items_sent = 0;
  sampling_scoreboard sb;

  weighted_farthest_point_sampling_core #(
    .MAX_CANDIDATES(CandDepth),
    .SAMPLES       (SampleGoal)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .vertex_id_i    (vertex_id),
    .weight_i       (weight),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .pos_z_i        (pos_z),
    .last_i         (last),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .sample_vertex_o(sample_vertex),
    .final_sample_o (final_sample)
  );

  always #2 clk = ~clk;

  task automatic send_beat(input logic [15:0] vid, input logic [15:0] wt,
                           input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] z, input logic lst);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    vertex_id <= vid;
    weight    <= wt;
    pos_x     <= x;
    pos_y     <= y;
    pos_z     <= z;
    last      <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(vid, wt, x, y, z, lst);
    items_sent++;
  endtask

  task automatic send_random_set(input int n, input int mode);
    logic [15:0] vid, wt, x, y, z;
    int          pool;
    pool = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      vid = 16'($urandom);
      wt  = 16'($urandom);
      x   = 16'($urandom);
      y   = 16'($urandom);
      z   = 16'($urandom);
      case (mode)
        1: vid = 16'($urandom_range(0, pool - 1));
        2: if ($urandom_range(0, 3) != 0) wt = 16'h0000;
        3: begin
          x = 16'($urandom_range(0, 8)) - 16'd4;
          y = 16'($urandom_range(0, 8)) - 16'd4;
          z = 16'($urandom_range(0, 8)) - 16'd4;
          case ($urandom_range(0, 2))
            0: wt = 16'hFFFF;
            1: wt = 16'h8000;
            default: wt = 16'h0000;
          endcase
        end
        4: begin
          x  = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
          y  = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
          z  = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
          wt = $urandom_range(0, 1) ? 16'hFFFF : 16'h0001;
        end
        default: ;
      endcase
      send_beat(vid, wt, x, y, z, k == n - 1);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(sample_vertex, final_sample);
  end

  initial begin
    int hold;
    bit stall_now;
    hold = 0;
    forever begin
      @(posedge clk);
      if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        if (hold == 0) begin
          stall_now = ($urandom_range(0, 2) == 0);
          hold      = $urandom_range(1, 14);
          out_stall <= stall_now;
        end
        hold--;
      end
    end
  end

  initial begin
    int r;
    int n;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_beat(16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 1'b1);

    send_beat(16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    send_beat(16'h0001, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 1'b1);

    send_beat(16'd5, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_beat(16'd5, 16'hFFFF, 16'h1000, 16'h0000, 16'h0000, 1'b0);
    send_beat(16'd5, 16'hFFFF, 16'h2000, 16'h0000, 16'h0000, 1'b0);
    send_beat(16'd6, 16'h0100, 16'h0000, 16'h0100, 16'h0000, 1'b1);

    send_beat(16'd20, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 1'b0);
    send_beat(16'd21, 16'h0000, 16'h0200, 16'h0000, 16'h0000, 1'b0);
    send_beat(16'd22, 16'h0000, 16'h0300, 16'h0000, 16'h0000, 1'b1);

    send_beat(16'd10, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_beat(16'd11, 16'h8000, 16'h0100, 16'h0000, 16'h0000, 1'b0);
    send_beat(16'd12, 16'h8000, 16'hFF00, 16'h0000, 16'h0000, 1'b1);

    for (int k = 0; k < 10; k++)
      send_beat(16'(100 + k), 16'(16'h1000 * (k + 1)), 16'(k * 300), 16'(-k * 200),
                16'(k * k * 50), k == 9);

    while (items_sent < ItemGoal) begin
      if (items_sent >= QuietFrom) quiet = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 5) n = $urandom_range(65, 72);
      else if (r < 20) n = $urandom_range(17, 64);
      else n = $urandom_range(1, 16);
      send_random_set(n, $urandom_range(0, 4));
    end
    quiet = 1'b1;
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * (CandDepth + 4)) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
